/* design/array_list_insert_delete_defines.svh */
// Assertion macros for the array list block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ARRAY_LIST_INSERT_DELETE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication.
`define ALS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("array list check failed");

// Next-cycle implication.
`define ALS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("array list check failed");

`endif

/* design/als_pkg.sv */
// ----------------------------------------------------------------------------
// als_pkg
// Shared types and defaults for the sequential array list.
// ----------------------------------------------------------------------------
package als_pkg;

  localparam int DEF_CAPACITY   = 128;
  localparam int DEF_ELEM_WIDTH = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_READ_HEAD,
    S_DEL_SHIFT,
    S_LOCATE
  } state_e;

endpackage

/* design/als_store.sv */
// ----------------------------------------------------------------------------
// als_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module als_store #(
  parameter int DEPTH = als_pkg::DEF_CAPACITY,
  parameter int WIDTH = als_pkg::DEF_ELEM_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/als_seq.sv */
// ----------------------------------------------------------------------------
// als_seq
// Operation sequencer: steps one store entry per cycle for shifts and search,
// with a single equality compare, and holds the length and the result.
// ----------------------------------------------------------------------------
module als_seq #(
  parameter int CAPACITY   = als_pkg::DEF_CAPACITY,
  parameter int ELEM_WIDTH = als_pkg::DEF_ELEM_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  operation_i,
  input  logic [6:0]                  position_i,
  input  logic signed [31:0]          value_i,
  output logic                        rd_en_o,
  output logic [$clog2(CAPACITY)-1:0] rd_addr_o,
  input  logic [ELEM_WIDTH-1:0]       rd_data_i,
  output logic                        wr_en_o,
  output logic [$clog2(CAPACITY)-1:0] wr_addr_o,
  output logic [ELEM_WIDTH-1:0]       wr_data_o,
  output logic                        result_valid_o,
  output als_pkg::status_e            status_o,
  output logic signed [31:0]          data_o,
  output logic [6:0]                  found_index_o,
  output logic [7:0]                  list_length_o,
  output logic                        is_empty_o
);

  import als_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > 7) ? CW : 7;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [ELEM_WIDTH-1:0]  val_q, val_d;
  logic                   del_q, del_d;
  logic                   done_q, done_d;
  status_e                status_q, status_d;
  logic signed [31:0]     data_q, data_d;
  logic [6:0]             found_q, found_d;

  logic [CMP_W-1:0]       pos_x, cnt_x;
  logic [CW-1:0]          ptr_next;
  logic                   more;

  assign pos_x    = CMP_W'(position_i);
  assign cnt_x    = CMP_W'(count_q);
  assign ptr_next = CW'(ptr_q) + CW'(1);
  // another entry lies past the pointer
  assign more     = (ptr_next < count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    del_q    <= del_d;
    status_q <= status_d;
    data_q   <= data_d;
    found_q  <= found_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    val_d     = val_q;
    del_d     = del_q;
    done_d    = 1'b0;
    status_d  = status_q;
    data_d    = data_q;
    found_d   = found_q;
    rd_en_o   = 1'b0;
    rd_addr_o = ptr_q;
    wr_en_o   = 1'b0;
    wr_addr_o = ptr_q;
    wr_data_o = rd_data_i;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          pos_d    = AW'(position_i);
          val_d    = ELEM_WIDTH'(value_i);
          del_d    = (op_e'(operation_i) == OP_DELETE);
          status_d = ST_OK;
          data_d   = '0;
          found_d  = '0;
          case (op_e'(operation_i))
            OP_INSERT: begin
              if (count_q >= CW'(CAPACITY)) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else if (pos_x > cnt_x) begin
                status_d = ST_RANGE;
                done_d   = 1'b1;
              end else if (pos_x == cnt_x) begin
                state_d = S_INS_PUT;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = AW'(count_q - CW'(1));
                ptr_d     = AW'(count_q - CW'(1));
                state_d   = S_INS_SHIFT;
              end
            end
            OP_DELETE, OP_GET: begin
              if (pos_x >= cnt_x) begin
                status_d = ST_RANGE;
                done_d   = 1'b1;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = AW'(position_i);
                state_d   = S_READ_HEAD;
              end
            end
            OP_LOCATE: begin
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
                done_d   = 1'b1;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = '0;
                ptr_d     = '0;
                state_d   = S_LOCATE;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // move entry ptr up by one, walking down toward the insert position
      S_INS_SHIFT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = ptr_q + AW'(1);
        wr_data_o = rd_data_i;
        if (ptr_q > pos_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = ptr_q - AW'(1);
          ptr_d     = ptr_q - AW'(1);
        end else begin
          state_d = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = pos_q;
        wr_data_o = val_q;
        count_d   = count_q + CW'(1);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_READ_HEAD: begin
        data_d = 32'(signed'(rd_data_i));
        if (!del_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if ((CW'(pos_q) + CW'(1)) < count_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = pos_q + AW'(1);
          ptr_d     = pos_q + AW'(1);
          state_d   = S_DEL_SHIFT;
        end else begin
          count_d = count_q - CW'(1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      // move entry ptr down by one, walking up toward the tail
      S_DEL_SHIFT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = ptr_q - AW'(1);
        wr_data_o = rd_data_i;
        if (more) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(ptr_next);
          ptr_d     = AW'(ptr_next);
        end else begin
          count_d = count_q - CW'(1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_LOCATE: begin
        if (rd_data_i == val_q) begin
          found_d = 7'(ptr_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (more) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(ptr_next);
          ptr_d     = AW'(ptr_next);
        end else begin
          status_d = ST_NOT_FOUND;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = done_q;
  assign status_o       = status_q;
  assign data_o         = data_q;
  assign found_index_o  = found_q;
  assign list_length_o  = 8'(count_q);
  assign is_empty_o     = (count_q == '0);

endmodule

/* design/array_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// array_list_insert_delete
// Fixed-capacity ordered list of signed values with insert, delete, get,
// locate and clear, one store entry moved or compared per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operation_i, position_i and value_i with start high; the item is
//   taken on a rising edge where busy is low. Exactly one result follows,
//   shown for one cycle with result_valid_o high: status_o, data_o,
//   found_index_o, list_length_o and is_empty_o.
// Timing:
//   clear, rejected items, unused codes: busy never rises, result in the
//     next cycle, so such items may follow every cycle.
//   insert, get, delete: busy while entries are read and moved; locate:
//     busy while it reads one entry per cycle until the first match. The
//     result appears in the same cycle that busy falls. Busy time is set
//     by the single read and write port of the element memory.
//   A new item may be taken in the same cycle its predecessor's result shows.
// Reset clears the length to zero; the element memory is not cleared.
// The receiver cannot stall: each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module array_list_insert_delete #(
  parameter int CAPACITY   = als_pkg::DEF_CAPACITY,
  parameter int ELEM_WIDTH = als_pkg::DEF_ELEM_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation_i,
  input  logic [6:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] data_o,
  output logic [6:0]         found_index_o,
  output logic [7:0]         list_length_o,
  output logic               is_empty_o
);

  import als_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [ELEM_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  status_e               status;

  als_seq #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .result_valid_o(result_valid_o),
    .status_o      (status),
    .data_o        (data_o),
    .found_index_o (found_index_o),
    .list_length_o (list_length_o),
    .is_empty_o    (is_empty_o)
  );

  als_store #(
    .DEPTH(CAPACITY),
    .WIDTH(ELEM_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  assign status_o = status;

endmodule

/* design/als_checker.sv */
// ----------------------------------------------------------------------------
// als_checker
// Port-level timing checks for the array list, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_list_insert_delete_defines.svh"

module als_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  // busy only rises right after an item was taken
  `ALS_ASSERT_IMP(a_busy_from_start, $rose(busy), $past(start))
  // a taken item either reports next cycle or keeps the block busy
  `ALS_ASSERT_NXT(a_item_progress, start && !busy, result_valid_o || busy)
  // results are only shown once the sequencer is back to idle
  `ALS_ASSERT_IMP(a_result_idle, result_valid_o, !busy)
  // a repeated strobe needs a fresh item in the strobe cycle
  `ALS_ASSERT_NXT(a_single_strobe, result_valid_o, !result_valid_o || $past(start))

endmodule

bind array_list_insert_delete als_checker u_als_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o)
);

/* tb/sv/array_list_insert_delete_tb.sv */
// ----------------------------------------------------------------------------
// array_list_insert_delete_tb
// Drives list operations through the start/busy handshake, mirrors the list
// contents in a queue and checks every result strobe against it. A short
// table of boundary items comes first, then random segments that grow,
// shrink, fill or balance the list, with random gaps between items.
// ----------------------------------------------------------------------------
module array_list_insert_delete_tb;
  import als_pkg::*;

  localparam int CAPACITY    = DEF_CAPACITY;
  localparam int N_DIRECTED  = 24;
  localparam int N_RANDOM    = 1400;
  localparam int RUN_LIMIT   = 1_500_000;
  localparam int MAX_REPORTS = 10;

  // codes outside op_e; the block returns an ok status and changes nothing
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef enum int {MIX_BALANCED, MIX_GROW, MIX_SHRINK, MIX_FILL} mix_e;
  typedef enum int {GAP_NONE, GAP_FULL, GAP_SHORT} gap_e;

  typedef struct packed {
    status_e             status;
    logic signed [31:0]  data;
    logic [6:0]          found;
    logic [7:0]          len;
    logic                empty;
  } list_result_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [6:0]          pos;
    logic signed [31:0]  val;
    logic                typed;
    list_result_t        res;
  } stim_row_t;

  localparam list_result_t NO_RES     = '0;
  localparam list_result_t EMPTY_RANGE = '{ST_RANGE, 32'sd0, 7'd0, 8'd0, 1'b1};

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         operation_i;
  logic [6:0]         position_i;
  logic signed [31:0] value_i;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic signed [31:0] data_o;
  logic [6:0]         found_index_o;
  logic [7:0]         list_length_o;
  logic               is_empty_o;

  logic signed [31:0] list_q[$];
  list_result_t       exp_results[$];
  int unsigned        failures;
  int unsigned        cycle_cnt;

  // typed rows: list state is easy to follow by hand from the top
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_GET,    7'd0,   32'sd0,          1'b1, EMPTY_RANGE},
    '{OP_DELETE, 7'd127, 32'sd0,          1'b1, EMPTY_RANGE},
    '{OP_LOCATE, 7'd0,   32'sd0,          1'b1, '{ST_NOT_FOUND, 32'sd0, 7'd0, 8'd0, 1'b1}},
    '{OP_INSERT, 7'd1,   32'sd5,          1'b1, EMPTY_RANGE},
    '{OP_INSERT, 7'd0,   VAL_MAX,         1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd1, 1'b0}},
    '{OP_INSERT, 7'd0,   VAL_MIN,         1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd2, 1'b0}},
    '{OP_INSERT, 7'd2,   -32'sd1,         1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd3, 1'b0}},
    '{OP_INSERT, 7'd1,   32'sd0,          1'b0, NO_RES},
    '{OP_GET,    7'd0,   32'sd0,          1'b1, '{ST_OK, VAL_MIN, 7'd0, 8'd4, 1'b0}},
    '{OP_GET,    7'd3,   32'sd0,          1'b0, NO_RES},
    '{OP_GET,    7'd4,   32'sd0,          1'b1, '{ST_RANGE, 32'sd0, 7'd0, 8'd4, 1'b0}},
    '{OP_LOCATE, 7'd0,   VAL_MAX,         1'b0, NO_RES},
    '{OP_LOCATE, 7'd0,   32'sh55555555,   1'b1, '{ST_NOT_FOUND, 32'sd0, 7'd0, 8'd4, 1'b0}},
    '{OP_INSERT, 7'd5,   32'sd1,          1'b1, '{ST_RANGE, 32'sd0, 7'd0, 8'd4, 1'b0}},
    '{OP_DELETE, 7'd1,   32'sd0,          1'b0, NO_RES},
    '{OP_DELETE, 7'd2,   32'sd0,          1'b0, NO_RES},
    '{OP_RSVD5,  7'd127, 32'shaaaaaaaa,   1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd2, 1'b0}},
    '{OP_RSVD6,  7'd0,   32'sd0,          1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd2, 1'b0}},
    '{OP_RSVD7,  7'd85,  -32'sd1,         1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd2, 1'b0}},
    '{OP_LOCATE, 7'd0,   VAL_MIN,         1'b0, NO_RES},
    '{OP_INSERT, 7'd1,   VAL_MIN,         1'b0, NO_RES},
    '{OP_LOCATE, 7'd0,   VAL_MIN,         1'b0, NO_RES},
    '{OP_CLEAR,  7'd0,   32'sd0,          1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd0, 1'b1}},
    '{OP_CLEAR,  7'd127, -32'sd1,         1'b1, '{ST_OK, 32'sd0, 7'd0, 8'd0, 1'b1}}
  };

  array_list_insert_delete dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .data_o         (data_o),
    .found_index_o  (found_index_o),
    .list_length_o  (list_length_o),
    .is_empty_o     (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // applies one operation to the mirrored list and returns the result it gives
  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic [6:0] pos,
                                                 input logic signed [31:0] val);
    list_result_t res;
    int unsigned  len;
    res        = '0;
    res.status = ST_OK;
    len        = list_q.size();
    case (op)
      OP_INSERT: begin
        if (len >= CAPACITY) res.status = ST_FULL;
        else if (pos > len) res.status = ST_RANGE;
        else list_q.insert(pos, val);
      end
      OP_DELETE: begin
        if (pos >= len) res.status = ST_RANGE;
        else begin
          res.data = list_q[pos];
          list_q.delete(pos);
        end
      end
      OP_GET: begin
        if (pos >= len) res.status = ST_RANGE;
        else res.data = list_q[pos];
      end
      OP_LOCATE: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < len && res.status == ST_NOT_FOUND; i++) begin
          if (list_q[i] == val) begin
            res.status = ST_OK;
            res.found  = 7'(i);
          end
        end
      end
      OP_CLEAR: list_q.delete();
      default: ;
    endcase
    res.len   = 8'(list_q.size());
    res.empty = (list_q.size() == 0);
    return res;
  endfunction

  function automatic int draw_gap(input gap_e style);
    case (style)
      GAP_NONE:  return 0;
      GAP_SHORT: return $urandom_range(0, 2);
      default:   return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return VAL_MAX;
    if (r < 8) return VAL_MIN;
    if (r < 12) return -32'sd1;
    if (r < 15) return 32'sd0;
    // a small pool makes duplicates, so locate has to return the first one
    if (r < 40) return 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic logic [6:0] pick_position(input logic [2:0] op);
    int unsigned len;
    int unsigned hi;
    int unsigned r;
    len = list_q.size();
    r   = $urandom_range(0, 99);
    if (r < 15 || (op != OP_INSERT && len == 0)) return 7'($urandom_range(0, 127));
    hi = (op == OP_INSERT) ? len : len - 1;
    if (hi > 127) hi = 127;
    if (r < 30) return 7'(hi);
    if (r < 38) return 7'd0;
    return 7'($urandom_range(0, hi));
  endfunction

  // holds start until the item is taken, then records what it should produce
  task automatic send_item(input logic [2:0] op, input logic [6:0] pos,
                           input logic signed [31:0] val, input logic typed,
                           input list_result_t typed_res);
    list_result_t predicted;
    operation_i <= op;
    position_i  <= pos;
    value_i     <= val;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy);
    predicted = apply_list_op(op, pos, val);
    exp_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_gap(input gap_e style);
    int gap;
    gap = draw_gap(style);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_item(input mix_e mix);
    int unsigned        r;
    int unsigned        ins_w, del_w, get_w, loc_w;
    logic [2:0]         op;
    logic signed [31:0] val;
    case (mix)
      MIX_GROW:   begin ins_w = 60; del_w = 15; get_w = 12; loc_w = 13; end
      MIX_SHRINK: begin ins_w = 15; del_w = 55; get_w = 15; loc_w = 15; end
      MIX_FILL:   begin ins_w = 85; del_w = 3;  get_w = 6;  loc_w = 6;  end
      default:    begin ins_w = 35; del_w = 30; get_w = 17; loc_w = 18; end
    endcase
    r = $urandom_range(0, 99);
    if (r < 1 && mix != MIX_FILL) op = OP_CLEAR;
    else if (r < 3) op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
    else begin
      r = $urandom_range(0, ins_w + del_w + get_w + loc_w - 1);
      if (r < ins_w) op = OP_INSERT;
      else if (r < ins_w + del_w) op = OP_DELETE;
      else if (r < ins_w + del_w + get_w) op = OP_GET;
      else op = OP_LOCATE;
    end
    val = pick_value();
    if (op == OP_LOCATE && list_q.size() > 0 && $urandom_range(0, 99) < 60)
      val = list_q[$urandom_range(0, list_q.size() - 1)];
    send_item(op, pick_position(op), val, 1'b0, NO_RES);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      if (exp_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: status=%0d data=%0d len=%0d", status_o, data_o,
                   list_length_o);
      end else begin
        list_result_t want;
        list_result_t got;
        want       = exp_results.pop_front();
        got.status = status_e'(status_o);
        got.data   = data_o;
        got.found  = found_index_o;
        got.len    = list_length_o;
        got.empty  = is_empty_o;
        if (got !== want) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("mismatch: exp st=%0d data=%0d idx=%0d len=%0d empty=%0d",
                     want.status, want.data, want.found, want.len, want.empty,
                     " | got st=%0d data=%0d idx=%0d len=%0d empty=%0d",
                     status_o, data_o, found_index_o, list_length_o, is_empty_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int   sent;
    int   seg_len;
    mix_e mix;
    gap_e gap_style;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    operation_i <= OP_GET;
    position_i  <= '0;
    value_i     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      wait_gap(GAP_FULL);
      send_item(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].res);
    end

    sent = 0;
    while (sent < N_RANDOM) begin
      mix       = mix_e'($urandom_range(MIX_BALANCED, MIX_FILL));
      gap_style = gap_e'($urandom_range(GAP_NONE, GAP_SHORT));
      // a fill run is long enough to reach capacity and hit it a few times
      seg_len   = (mix == MIX_FILL) ? 170 : $urandom_range(30, 90);
      if (seg_len > N_RANDOM - sent) seg_len = N_RANDOM - sent;
      repeat (seg_len) begin
        wait_gap(gap_style);
        send_random_item(mix);
        sent++;
      end
    end
    start <= 1'b0;

    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (failures == 0 && exp_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
